// ----- rtl/pbts_pkg.sv -----
// Shared types, codes and helpers for the priority bitmap task scheduler.
package pbts_pkg;

  localparam int WORD_BITS = 64;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_PICK   = 3'd2;
  localparam logic [2:0] OP_SETPRI = 3'd3;
  localparam logic [2:0] OP_MIGR   = 3'd4;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_IGNORE = 2'd3;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] task_id;
    logic [7:0] priority_req;
    logic [2:0] cpu;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] chosen_task;
    logic [2:0] assigned_cpu;
    logic [8:0] running_count;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic [3:0] ncpu;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PICK_HEAD,
    S_U_Q,
    S_U_UPD,
    S_U_PV,
    S_U_NX,
    S_A_RD,
    S_A_UPD,
    S_A_TL,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    P_RESP,
    P_SCAN,
    P_ADD,
    P_UNLINK
  } path_t;

  typedef struct packed {
    logic       found;
    logic [5:0] idx;
  } ffs_t;

  // lowest set bit of one bitmap word
  function automatic ffs_t ffs64(input logic [WORD_BITS-1:0] bits);
    ffs_t r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (bits[i]) begin
        r.found = 1'b1;
        r.idx   = 6'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/priority_bitmap_task_scheduler.sv -----
// Top level: per-CPU priority bitmap run queues with a list sequencer.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_data  (in_item_t)
//  out_    | output    | out_valid/out_stall| out_data (out_item_t)
//  cfg     | input     | psel/penable/pwrite| paddr/pwdata, prdata, pready
//
// One operation at a time. Each operation that changes the queues runs as a
// chain of dependent read-modify-write steps on the task and queue RAMs; a pick
// first scans the bitmap word by word, and a migrate to the task's own CPU stops
// after reading the task entry.
// Reset (synchronous, rst_n low) clears queued bits, bitmaps, CPU counts and the
// round-robin pointer; the RAMs need no clearing pass.
// A finished result waits in the output register; a new transfer is taken
// while it waits, and the sequencer holds in its result state only if the
// output register is still occupied.
module priority_bitmap_task_scheduler #(
  parameter int TASK_SLOTS      = 256,
  parameter int PRIORITY_LEVELS = 128,
  parameter int CPU_COUNT       = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pbts_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pbts_pkg::*;

  localparam int TW        = $clog2(TASK_SLOTS);
  localparam int LW        = $clog2(PRIORITY_LEVELS);
  localparam int CW        = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int RW        = $clog2(TASK_SLOTS + 1);
  localparam int QDEPTH    = CPU_COUNT * PRIORITY_LEVELS;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int MAP_WORDS = (PRIORITY_LEVELS + WORD_BITS - 1) / WORD_BITS;
  localparam int WWD       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int QW        = 2 * TW + RW;            // head, tail, count
  localparam int TEW       = LW + CW + 2 * TW;       // level, home, next, prev

  // ---------------- configuration ----------------
  cfg_t cfg;

  pbts_cfg #(.CPU_COUNT(CPU_COUNT)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // ---------------- state ----------------
  state_t state_r, state_nxt;

  logic [2:0]     op_r;
  logic [CW-1:0]  cpu_r;
  logic [LW-1:0]  lvl_r;
  logic [TW-1:0]  t_r;
  logic [CW-1:0]  home_r;
  logic [LW-1:0]  tlvl_r;
  logic [TW-1:0]  nx_r, pv_r, tl_r;
  logic           ish_r, ist_r, a_has_r;
  logic [CW-1:0]  a_cpu_r;
  logic [LW-1:0]  a_lvl_r;
  logic [QAW-1:0] q_r;
  logic [WWD-1:0] w_r;
  logic [1:0]     st_r;
  logic [7:0]     chosen_r;
  logic [CW-1:0]  acpu_r;
  logic           cz_r;
  logic [CW-1:0]  rr_r;

  logic                       queued_r  [TASK_SLOTS];
  logic [PRIORITY_LEVELS-1:0] bm_r      [CPU_COUNT];
  logic [RW-1:0]              running_r [CPU_COUNT];

  logic      out_valid_r;
  out_item_t out_r;

  // ---------------- RAMs ----------------
  logic            t_we, t_re;
  logic [TW-1:0]   t_waddr, t_raddr;
  logic [TEW-1:0]  t_wdata, t_rdata;
  logic            q_we, q_re;
  logic [QAW-1:0]  q_waddr, q_raddr;
  logic [QW-1:0]   q_wdata, q_rdata;

  pbts_ram #(.WIDTH(TEW), .DEPTH(TASK_SLOTS)) u_task_ram (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata_r(t_rdata)
  );

  pbts_ram #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue_ram (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata_r(q_rdata)
  );

  function automatic logic [QAW-1:0] qaddr(input logic [CW-1:0] c, input logic [LW-1:0] l);
    return QAW'(c) * QAW'(PRIORITY_LEVELS) + QAW'(l);
  endfunction

  // RAM entry fields
  logic [TW-1:0] q_head, q_tail;
  logic [RW-1:0] q_cnt;
  logic [LW-1:0] e_lvl;
  logic [CW-1:0] e_home;
  logic [TW-1:0] e_next, e_prev;

  assign q_head = q_rdata[QW-1 -: TW];
  assign q_tail = q_rdata[RW+TW-1 -: TW];
  assign q_cnt  = q_rdata[RW-1:0];
  assign e_lvl  = t_rdata[TEW-1 -: LW];
  assign e_home = t_rdata[2*TW+CW-1 -: CW];
  assign e_next = t_rdata[2*TW-1 -: TW];
  assign e_prev = t_rdata[TW-1:0];

  // ---------------- input decode ----------------
  logic [TW+7:0] tid_ext;
  logic [TW-1:0] tid_idx;
  logic [LW+7:0] prq_ext;
  logic [LW-1:0] lvl_in;
  logic [CW+2:0] cpu_ext;
  logic [CW-1:0] cpu_idx;
  logic          tid_ok, cpu_ok, queued_in, acc;
  logic [CW-1:0] rr_c, rr_n;
  path_t         dec;
  logic [1:0]    dec_st;

  assign tid_ext = {{TW{1'b0}}, in_data.task_id};
  assign tid_idx = tid_ext[TW-1:0];
  assign prq_ext = {{LW{1'b0}}, in_data.priority_req};
  assign lvl_in  = (32'(in_data.priority_req) >= PRIORITY_LEVELS) ?
                   LW'(PRIORITY_LEVELS - 1) : prq_ext[LW-1:0];
  assign cpu_ext = {{CW{1'b0}}, in_data.cpu};
  assign cpu_idx = cpu_ext[CW-1:0];

  assign tid_ok    = 32'(in_data.task_id) < TASK_SLOTS;
  assign cpu_ok    = {1'b0, in_data.cpu} < cfg.ncpu;
  assign queued_in = tid_ok && queued_r[tid_idx];
  assign acc       = in_valid && !in_stall;

  // stored pointer at or above the CPUs in use reads as zero
  assign rr_c = (8'(rr_r) >= 8'(cfg.ncpu)) ? '0 : rr_r;
  assign rr_n = (8'(rr_c) + 8'd1 >= 8'(cfg.ncpu)) ? '0 : rr_c + CW'(1);

  always_comb begin
    dec    = P_RESP;
    dec_st = ST_DONE;
    priority if (!cfg.en) begin
      dec_st = ST_REJECT;
    end else if (in_data.operation > OP_MIGR) begin
      dec_st = ST_IGNORE;
    end else if (in_data.operation == OP_PICK) begin
      if (cpu_ok) begin
        dec = P_SCAN;
      end else begin
        dec_st = ST_REJECT;
      end
    end else if (in_data.operation == OP_MIGR && !cpu_ok) begin
      dec_st = ST_REJECT;
    end else if (!tid_ok) begin
      dec_st = ST_IGNORE;
    end else if (in_data.operation == OP_ADD) begin
      if (queued_in) begin
        dec_st = ST_IGNORE;
      end else begin
        dec = P_ADD;
      end
    end else if (queued_in) begin
      dec = P_UNLINK;
    end else begin
      dec_st = ST_IGNORE;
    end
  end

  // ---------------- shared per-CPU read ----------------
  logic [CW-1:0]                   sel_cpu;
  logic [PRIORITY_LEVELS-1:0]      bm_row;
  logic [RW-1:0]                   run_cur;
  logic [MAP_WORDS*WORD_BITS-1:0]  bm_pad;
  ffs_t                            ffs;
  logic [WWD+5:0]                  lvl_full;
  logic [LW-1:0]                   lvl_found;
  logic [TW+7:0]                   head_ext;
  logic [RW-1:0]                   a_cnt;
  logic                            mig_same, out_free;

  always_comb begin
    unique case (state_r)
      S_SCAN:  sel_cpu = cpu_r;
      S_U_UPD: sel_cpu = home_r;
      S_A_UPD: sel_cpu = a_cpu_r;
      default: sel_cpu = acpu_r;
    endcase
  end

  assign bm_row    = bm_r[sel_cpu];
  assign run_cur   = running_r[sel_cpu];
  assign bm_pad    = (MAP_WORDS*WORD_BITS)'(bm_row);
  assign ffs       = ffs64(bm_pad[w_r*WORD_BITS +: WORD_BITS]);
  assign lvl_full  = {w_r, ffs.idx};
  assign lvl_found = lvl_full[LW-1:0];
  assign head_ext  = {8'b0, q_head};
  // a clear bitmap bit means the stored count is stale: treat as empty
  assign a_cnt     = bm_row[a_lvl_r] ? q_cnt : '0;
  assign mig_same  = (op_r == OP_MIGR) && (e_home == cpu_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (dec)
            P_RESP:   state_nxt = S_RESP;
            P_SCAN:   state_nxt = S_SCAN;
            P_ADD:    state_nxt = S_A_UPD;
            P_UNLINK: state_nxt = S_U_Q;
          endcase
        end
      end
      S_SCAN: begin
        if (ffs.found) begin
          state_nxt = S_PICK_HEAD;
        end else if (32'(w_r) == MAP_WORDS - 1) begin
          state_nxt = S_RESP;
        end
      end
      S_PICK_HEAD: state_nxt = S_U_Q;
      S_U_Q:       state_nxt = mig_same ? S_RESP : S_U_UPD;
      S_U_UPD:     state_nxt = S_U_PV;
      S_U_PV:      state_nxt = S_U_NX;
      S_U_NX: begin
        state_nxt = (op_r == OP_SETPRI || op_r == OP_MIGR) ? S_A_RD : S_RESP;
      end
      S_A_RD:      state_nxt = S_A_UPD;
      S_A_UPD:     state_nxt = S_A_TL;
      S_A_TL:      state_nxt = S_RESP;
      S_RESP:      state_nxt = out_free ? S_IDLE : S_RESP;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // ---------------- RAM control ----------------
  always_comb begin
    t_we = 1'b0; t_waddr = t_r;  t_wdata = t_rdata;
    t_re = 1'b0; t_raddr = t_r;
    q_we = 1'b0; q_waddr = q_r;  q_wdata = q_rdata;
    q_re = 1'b0; q_raddr = q_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && dec == P_UNLINK) begin
          t_re    = 1'b1;
          t_raddr = tid_idx;
        end
        if (acc && dec == P_ADD) begin
          q_re    = 1'b1;
          q_raddr = qaddr(rr_c, lvl_in);
        end
      end
      S_SCAN: begin
        if (ffs.found) begin
          q_re    = 1'b1;
          q_raddr = qaddr(cpu_r, lvl_found);
        end
      end
      S_PICK_HEAD: begin
        t_re    = 1'b1;
        t_raddr = q_head;
      end
      S_U_Q: begin
        if (!mig_same) begin
          q_re    = 1'b1;
          q_raddr = qaddr(e_home, e_lvl);
        end
      end
      S_U_UPD: begin
        q_we    = 1'b1;
        q_wdata = {(q_head == t_r) ? nx_r : q_head,
                   (q_tail == t_r) ? pv_r : q_tail,
                   q_cnt - RW'(1)};
        if (q_head != t_r) begin
          t_re    = 1'b1;
          t_raddr = pv_r;
        end
      end
      S_U_PV: begin
        if (!ish_r) begin
          t_we    = 1'b1;
          t_waddr = pv_r;
          t_wdata = {e_lvl, e_home, nx_r, e_prev};
        end
        if (!ist_r) begin
          t_re    = 1'b1;
          t_raddr = nx_r;
        end
      end
      S_U_NX: begin
        if (!ist_r) begin
          t_we    = 1'b1;
          t_waddr = nx_r;
          t_wdata = {e_lvl, e_home, e_next, pv_r};
        end
      end
      S_A_RD: begin
        q_re    = 1'b1;
        q_raddr = qaddr(a_cpu_r, a_lvl_r);
      end
      S_A_UPD: begin
        q_we    = 1'b1;
        q_wdata = {(a_cnt == '0) ? t_r : q_head, t_r, a_cnt + RW'(1)};
        t_we    = 1'b1;
        t_waddr = t_r;
        t_wdata = {a_lvl_r, a_cpu_r, t_r, q_tail};
        if (a_cnt != '0) begin
          t_re    = 1'b1;
          t_raddr = q_tail;
        end
      end
      S_A_TL: begin
        if (a_has_r) begin
          t_we    = 1'b1;
          t_waddr = tl_r;
          t_wdata = {e_lvl, e_home, t_r, e_prev};
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rr_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) queued_r[i] <= 1'b0;
      for (int c = 0; c < CPU_COUNT; c++) begin
        bm_r[c]      <= '0;
        running_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && acc && dec == P_ADD) begin
        rr_r <= rr_n;
      end
      if (state_r == S_U_UPD) begin
        queued_r[t_r] <= 1'b0;
        if (q_cnt == RW'(1)) bm_r[home_r][tlvl_r] <= 1'b0;
        if (run_cur != '0) running_r[home_r] <= run_cur - RW'(1);
      end
      if (state_r == S_A_UPD) begin
        queued_r[t_r]          <= 1'b1;
        bm_r[a_cpu_r][a_lvl_r] <= 1'b1;
        running_r[a_cpu_r]     <= run_cur + RW'(1);
      end
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- working registers ----------------
  logic [CW+2:0] acpu_ext;
  logic [RW+8:0] run_ext;

  assign acpu_ext = {3'b0, acpu_r};
  assign run_ext  = {9'b0, run_cur};

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_r     <= in_data.operation;
          cpu_r    <= cpu_idx;
          lvl_r    <= lvl_in;
          t_r      <= tid_idx;
          chosen_r <= in_data.task_id;
          st_r     <= dec_st;
          acpu_r   <= (dec == P_ADD) ? rr_c : '0;
          cz_r     <= (dec == P_RESP);
          w_r      <= '0;
          if (dec == P_ADD) begin
            a_cpu_r <= rr_c;
            a_lvl_r <= lvl_in;
            q_r     <= qaddr(rr_c, lvl_in);
          end
        end
      end
      S_SCAN: begin
        if (!ffs.found) begin
          if (32'(w_r) == MAP_WORDS - 1) begin
            st_r     <= ST_IDLE;
            chosen_r <= 8'd0;
            acpu_r   <= cpu_r;
          end else begin
            w_r <= w_r + WWD'(1);
          end
        end
      end
      S_PICK_HEAD: begin
        t_r      <= q_head;
        chosen_r <= head_ext[7:0];
        acpu_r   <= cpu_r;
      end
      S_U_Q: begin
        home_r <= e_home;
        tlvl_r <= e_lvl;
        nx_r   <= e_next;
        pv_r   <= e_prev;
        q_r    <= qaddr(e_home, e_lvl);
        if (op_r == OP_MIGR) begin
          acpu_r  <= cpu_r;
          a_cpu_r <= cpu_r;
          a_lvl_r <= e_lvl;
        end else begin
          a_cpu_r <= e_home;
          a_lvl_r <= lvl_r;
          if (op_r != OP_PICK) acpu_r <= e_home;
        end
      end
      S_U_UPD: begin
        ish_r <= (q_head == t_r);
        ist_r <= (q_tail == t_r);
      end
      S_A_RD: begin
        q_r <= qaddr(a_cpu_r, a_lvl_r);
      end
      S_A_UPD: begin
        tl_r    <= q_tail;
        a_has_r <= (a_cnt != '0);
      end
      S_RESP: begin
        if (out_free) begin
          out_r.status        <= st_r;
          out_r.chosen_task   <= chosen_r;
          out_r.assigned_cpu  <= acpu_ext[2:0];
          out_r.running_count <= cz_r ? 9'd0 : run_ext[8:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_unlink_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_U_UPD |-> bm_r[home_r][tlvl_r])
    else $error("unlink from a level marked empty");

  a_unlink_queued: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_U_UPD |-> queued_r[t_r])
    else $error("unlink of a task not queued");

  a_append_marks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_A_UPD |=> queued_r[t_r] && bm_r[a_cpu_r][a_lvl_r])
    else $error("append did not mark task and level");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result loaded outside result state");
`endif

endmodule

// ----- rtl/pbts_ram.sv -----
// Generic simple dual-port RAM with registered read.
module pbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- rtl/pbts_cfg.sv -----
// Configuration registers and APB-style access for the scheduler.
module pbts_cfg #(
  parameter int CPU_COUNT = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output pbts_pkg::cfg_t cfg
);
  import pbts_pkg::*;

  logic [3:0] cpus_r;
  logic       en_r;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpus_r <= 4'd1;
      en_r   <= 1'b0;
    end else if (wr) begin
      if (paddr[2]) begin
        en_r <= pwdata[0];
      end else begin
        cpus_r <= pwdata[3:0];
      end
    end
  end

  assign prdata = paddr[2] ? {31'b0, en_r} : {28'b0, cpus_r};

  // zero acts as one, oversize clamps to the CPU count
  always_comb begin
    cfg.en = en_r;
    if (cpus_r == 4'd0) begin
      cfg.ncpu = 4'd1;
    end else if (8'(cpus_r) > 8'(CPU_COUNT)) begin
      cfg.ncpu = 4'(CPU_COUNT);
    end else begin
      cfg.ncpu = cpus_r;
    end
  end

endmodule

// ----- test/priority_bitmap_task_scheduler_tb.sv -----
// Self-checking testbench for the per-CPU priority bitmap task scheduler.
`timescale 1ns / 100ps

module priority_bitmap_task_scheduler_tb;
  import pbts_pkg::*;

  localparam logic [2:0] REG_CPUS   = 3'd0;
  localparam logic [2:0] REG_ENABLE = 3'd4;
  localparam int         NCPU_MAX   = 8;
  localparam int         NLEVELS    = 128;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  priority_bitmap_task_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the scheduler: one FIFO per (cpu, level), queued flags, counts.
  logic [7:0] run_list [NCPU_MAX][NLEVELS][$];
  logic       queued_flag [256];
  logic [2:0] home_cpu [256];
  logic [6:0] home_level [256];
  logic [8:0] cpu_load [NCPU_MAX];
  logic [2:0] rr_next;
  logic [3:0] cpus_reg;
  logic       enable_reg;

  out_item_t expected_results [$];
  int        errors = 0;
  bit        idle_on = 1'b1;     // random gaps on both channels
  bit        hold_out = 1'b0;    // long receiver hold-off

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int cpus_effective();
    if (cpus_reg == 0) return 1;
    if (cpus_reg > NCPU_MAX) return NCPU_MAX;
    return cpus_reg;
  endfunction

  function automatic void list_append(input logic [7:0] t, input logic [2:0] c,
                                      input logic [6:0] lv);
    run_list[c][lv].push_back(t);
    cpu_load[c]++;
    queued_flag[t] = 1'b1;
    home_cpu[t] = c;
    home_level[t] = lv;
  endfunction

  function automatic void list_unlink(input logic [7:0] t);
    logic [2:0] c;
    logic [6:0] lv;
    c = home_cpu[t];
    lv = home_level[t];
    foreach (run_list[c][lv][i]) begin
      if (run_list[c][lv][i] == t) begin
        run_list[c][lv].delete(i);
        break;
      end
    end
    cpu_load[c]--;
    queued_flag[t] = 1'b0;
  endfunction

  // Expected result for one accepted operation; updates the shadow state.
  function automatic out_item_t sched_predict(input in_item_t it);
    out_item_t  r;
    int         ncpu;
    int         pick_lv;
    logic [6:0] lv;
    logic [2:0] c;
    logic [7:0] t;
    ncpu = cpus_effective();
    lv = (it.priority_req >= NLEVELS) ? 7'(NLEVELS - 1) : it.priority_req[6:0];
    r = '{status: ST_REJECT, chosen_task: it.task_id, assigned_cpu: '0, running_count: '0};
    if (!enable_reg) return r;
    if (it.operation > OP_MIGR) begin
      r.status = ST_IGNORE;
      return r;
    end
    if (it.operation == OP_PICK) begin
      if (it.cpu >= ncpu) return r;
      pick_lv = -1;
      for (int l = 0; l < NLEVELS; l++) begin
        if (run_list[it.cpu][l].size() != 0) begin
          pick_lv = l;
          break;
        end
      end
      if (pick_lv < 0) begin
        r = '{status: ST_IDLE, chosen_task: '0, assigned_cpu: it.cpu,
              running_count: cpu_load[it.cpu]};
        return r;
      end
      t = run_list[it.cpu][pick_lv][0];
      list_unlink(t);
      r = '{status: ST_DONE, chosen_task: t, assigned_cpu: it.cpu,
            running_count: cpu_load[it.cpu]};
      return r;
    end
    if (it.operation == OP_MIGR && it.cpu >= ncpu) return r;
    r.status = ST_IGNORE;
    if (it.operation == OP_ADD) begin
      if (queued_flag[it.task_id]) return r;
      c = (rr_next >= ncpu) ? 3'd0 : rr_next;
      rr_next = (c + 1 >= ncpu) ? 3'd0 : 3'(c + 1);
      list_append(it.task_id, c, lv);
      r = '{status: ST_DONE, chosen_task: it.task_id, assigned_cpu: c,
            running_count: cpu_load[c]};
      return r;
    end
    if (!queued_flag[it.task_id]) return r;
    c = home_cpu[it.task_id];
    if (it.operation == OP_REMOVE) begin
      list_unlink(it.task_id);
    end else if (it.operation == OP_SETPRI) begin
      list_unlink(it.task_id);
      list_append(it.task_id, c, lv);
    end else begin
      if (c != it.cpu) begin
        lv = home_level[it.task_id];
        list_unlink(it.task_id);
        list_append(it.task_id, it.cpu, lv);
      end
      c = it.cpu;
    end
    r = '{status: ST_DONE, chosen_task: it.task_id, assigned_cpu: c,
          running_count: cpu_load[c]};
    return r;
  endfunction

  // Register write: setup then access phase; only called while idle.
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_CPUS) cpus_reg = val[3:0];
    else if (addr == REG_ENABLE) enable_reg = val[0];
  endtask

  // Offer one operation; returns once the transfer has happened.
  task automatic send_op(input logic [2:0] op, input logic [7:0] tid,
                         input logic [7:0] prq, input logic [2:0] c);
    in_item_t it;
    it = '{operation: op, task_id: tid, priority_req: prq, cpu: c};
    if (idle_on) begin
      while ($urandom_range(99) < 15) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(sched_predict(it));
  endtask

  // Drop valid, wait until every result is back and then idle on,
  // which also covers any operation still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Receiver: random stalls unless a hold-off is in progress.
  always @(posedge clk) begin
    out_stall <= hold_out || (idle_on && $urandom_range(99) < 15);
  end

  // Result checker: compares each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, chosen_task", out_data.chosen_task, -1);
      end else begin
        out_item_t want;
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.chosen_task !== want.chosen_task)
          report_mismatch("chosen_task", out_data.chosen_task, want.chosen_task);
        if (out_data.assigned_cpu !== want.assigned_cpu)
          report_mismatch("assigned_cpu", out_data.assigned_cpu, want.assigned_cpu);
        if (out_data.running_count !== want.running_count)
          report_mismatch("running_count", out_data.running_count, want.running_count);
      end
    end
  end

  // Disabled block, bogus operations, clamping, duplicates, idle pick.
  task automatic test_directed_basic();
    send_op(OP_ADD, 8'd1, 8'd0, 3'd0);            // rejected while disabled
    send_op(3'd7, 8'd255, 8'd255, 3'd7);
    drain();
    cfg_write(REG_ENABLE, 32'd1);
    send_op(OP_PICK, 8'd0, 8'd0, 3'd0);           // empty queue -> idle task
    send_op(OP_ADD, 8'd0, 8'd0, 3'd0);
    send_op(OP_ADD, 8'd255, 8'd255, 3'd0);        // level clamps to the last one
    send_op(OP_ADD, 8'd0, 8'd5, 3'd0);            // already queued
    send_op(OP_REMOVE, 8'd9, 8'd0, 3'd0);         // not queued
    send_op(OP_SETPRI, 8'd10, 8'd0, 3'd0);
    send_op(OP_MIGR, 8'd11, 8'd0, 3'd0);
    send_op(3'd5, 8'd0, 8'd0, 3'd0);
    send_op(3'd6, 8'd0, 8'd0, 3'd0);
    send_op(OP_PICK, 8'd0, 8'd0, 3'd1);           // cpu out of range
    send_op(OP_MIGR, 8'd0, 8'd0, 3'd3);
    send_op(OP_SETPRI, 8'd255, 8'd128, 3'd0);
    send_op(OP_MIGR, 8'd0, 8'd0, 3'd0);           // same cpu: no move
    send_op(OP_PICK, 8'd0, 8'd0, 3'd0);
    drain();
  endtask

  // Round-robin wrap and a stale pointer after the cpu count shrinks.
  task automatic test_directed_cpus();
    cfg_write(REG_CPUS, 32'd8);
    for (int i = 0; i < 5; i++) send_op(OP_ADD, 8'(20 + i), 8'(i), 3'd0);
    send_op(OP_MIGR, 8'd20, 8'd0, 3'd7);
    send_op(OP_PICK, 8'd0, 8'd0, 3'd7);
    drain();
    cfg_write(REG_CPUS, 32'd2);                   // pointer 5 now reads as 0
    send_op(OP_ADD, 8'd30, 8'd3, 3'd0);
    send_op(OP_ADD, 8'd31, 8'd3, 3'd0);
    drain();
    cfg_write(REG_CPUS, 32'd0);                   // acts as one cpu
    send_op(OP_PICK, 8'd0, 8'd0, 3'd1);
    send_op(OP_PICK, 8'd0, 8'd0, 3'd0);
    drain();
    cfg_write(REG_CPUS, 32'd15);                  // acts as eight
    send_op(OP_PICK, 8'd0, 8'd0, 3'd7);
    send_op(OP_REMOVE, 8'd31, 8'd0, 3'd0);
    drain();
  endtask

  // Mostly legal traffic over a small task pool so that operations hit queued
  // tasks; a few full-range ids, priorities and unknown codes as noise.
  task automatic test_random_phase(input int n, input int pool);
    int         roll;
    logic [2:0] op;
    logic [7:0] tid, prq;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 30) op = OP_ADD;
      else if (roll < 50) op = OP_PICK;
      else if (roll < 65) op = OP_REMOVE;
      else if (roll < 80) op = OP_SETPRI;
      else if (roll < 95) op = OP_MIGR;
      else op = 3'($urandom_range(7));
      tid = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(pool - 1));
      prq = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
      send_op(op, tid, prq, 3'($urandom_range(7)));
    end
    drain();
  endtask

  // Receiver holds off for a long stretch while operations keep coming.
  task automatic test_backpressure();
    hold_out = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_out = 1'b0;
      end
    join_none
    test_random_phase(30, 16);
  endtask

  initial begin
    cpus_reg = 4'd1;
    enable_reg = 1'b0;
    rr_next = '0;
    foreach (queued_flag[i]) queued_flag[i] = 1'b0;
    foreach (cpu_load[i]) cpu_load[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basic();
    test_directed_cpus();

    cfg_write(REG_CPUS, 32'd1);
    test_random_phase(250, 24);
    cfg_write(REG_CPUS, 32'd8);
    idle_on = 1'b0;                               // stretch with no gaps
    test_random_phase(250, 48);
    idle_on = 1'b1;
    test_backpressure();
    cfg_write(REG_CPUS, 32'd3);
    test_random_phase(250, 32);
    cfg_write(REG_ENABLE, 32'd0);
    test_random_phase(40, 32);
    cfg_write(REG_ENABLE, 32'd1);
    cfg_write(REG_CPUS, 32'd0);
    test_random_phase(200, 16);
    cfg_write(REG_CPUS, 32'd15);
    test_random_phase(250, 64);
    cfg_write(REG_CPUS, 32'd5);
    test_random_phase(250, 40);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
